// ===== design/fc_pkg.sv =====
// Shared types and constants for the frustum cull test block.
package fc_pkg;

  localparam int REG_COUNT = 6;
  localparam int REG_IDX_W = 3;
  localparam int PLANE_W   = 64;
  localparam int FRAC_BITS = 14;

  localparam int NX_LSB = 0;
  localparam int NY_LSB = 16;
  localparam int NZ_LSB = 32;
  localparam int D_LSB  = 48;

  localparam logic [1:0] CLASS_INSIDE     = 2'd0;
  localparam logic [1:0] CLASS_INTERSECTS = 2'd1;
  localparam logic [1:0] CLASS_OUTSIDE    = 2'd2;

  localparam int OUT_TDATA_W = 8;

  typedef struct packed {
    logic skip;
    logic sph_out;
    logic sph_cross;
    logic cube_out;
    logic cube_cross;
  } fc_flags_t;

endpackage

// ===== design/fc_cell.sv =====
// One plane cell: holds a plane, tests the passing object against it, hands it on.
module fc_cell #(
  parameter int CB = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [fc_pkg::PLANE_W-1:0]   cfg_wdata,
  input  logic                         up_valid,
  output logic                         up_ready,
  input  logic signed [CB-1:0]         up_cx,
  input  logic signed [CB-1:0]         up_cy,
  input  logic signed [CB-1:0]         up_cz,
  input  logic [CB-2:0]                up_rad,
  input  fc_pkg::fc_flags_t            up_flags,
  output logic                         dn_valid,
  input  logic                         dn_ready,
  output logic signed [CB-1:0]         dn_cx,
  output logic signed [CB-1:0]         dn_cy,
  output logic signed [CB-1:0]         dn_cz,
  output logic [CB-2:0]                dn_rad,
  output fc_pkg::fc_flags_t            dn_flags
);
  import fc_pkg::*;

  localparam int PW = CB + 16;
  localparam int RW = CB + 16;
  localparam int DW = (CB + 20 > 34) ? CB + 20 : 34;

  logic [PLANE_W-1:0] plane_r;

  logic signed [15:0] nx, ny, nz, dpl;
  logic signed [16:0] nxe, nye, nze;
  logic [16:0]        anx, any_n, anz, abssum;

  logic                a_v_r;
  logic signed [PW-1:0] a_px_r, a_py_r, a_pz_r;
  logic [RW-1:0]        a_pr_r;
  logic signed [CB-1:0] a_cx_r, a_cy_r, a_cz_r;
  logic [CB-2:0]        a_rad_r;
  fc_flags_t            a_flags_r;
  logic                 a_rdy;

  logic                 b_v_r;
  logic signed [CB-1:0] b_cx_r, b_cy_r, b_cz_r;
  logic [CB-2:0]        b_rad_r;
  fc_flags_t            b_flags_r;
  fc_flags_t            b_flags_nxt;
  logic                 b_rdy;

  logic signed [DW-1:0] dot, dq, big_r, rr, pdist, s_lo, s_hi, c_lo, c_hi;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      plane_r <= '0;
    end else if (cfg_we) begin
      plane_r <= cfg_wdata;
    end
  end

  assign nx  = plane_r[NX_LSB +: 16];
  assign ny  = plane_r[NY_LSB +: 16];
  assign nz  = plane_r[NZ_LSB +: 16];
  assign dpl = plane_r[D_LSB +: 16];

  assign nxe    = 17'(nx);
  assign nye    = 17'(ny);
  assign nze    = 17'(nz);
  assign anx    = nxe[16] ? 17'(-nxe) : 17'(nxe);
  assign any_n  = nye[16] ? 17'(-nye) : 17'(nye);
  assign anz    = nze[16] ? 17'(-nze) : 17'(nze);
  assign abssum = anx + any_n + anz;

  assign b_rdy    = !b_v_r || dn_ready;
  assign a_rdy    = !a_v_r || b_rdy;
  assign up_ready = a_rdy;

  // stage A: products
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
    end else if (a_rdy) begin
      a_v_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (a_rdy && up_valid) begin
      a_px_r    <= PW'(nx) * PW'(up_cx);
      a_py_r    <= PW'(ny) * PW'(up_cy);
      a_pz_r    <= PW'(nz) * PW'(up_cz);
      a_pr_r    <= RW'(up_rad) * RW'(abssum);
      a_cx_r    <= up_cx;
      a_cy_r    <= up_cy;
      a_cz_r    <= up_cz;
      a_rad_r   <= up_rad;
      a_flags_r <= up_flags;
    end
  end

  // stage B: sums and compares
  assign dot   = DW'(a_px_r) + DW'(a_py_r) + DW'(a_pz_r);
  assign dq    = DW'(dpl) <<< FRAC_BITS;
  assign big_r = DW'({a_rad_r, {FRAC_BITS{1'b0}}});
  assign rr    = DW'(a_pr_r);
  assign pdist = dot + dq;
  assign s_lo  = pdist + big_r;
  assign s_hi  = pdist - big_r;
  assign c_lo  = pdist + rr;
  assign c_hi  = pdist - rr;

  always_comb begin
    b_flags_nxt            = a_flags_r;
    b_flags_nxt.sph_out    = a_flags_r.sph_out || (s_lo < 0);
    b_flags_nxt.sph_cross  = a_flags_r.sph_cross || ((s_lo > 0) && (s_hi < 0));
    b_flags_nxt.cube_out   = a_flags_r.cube_out || (c_lo < 0);
    b_flags_nxt.cube_cross = a_flags_r.cube_cross || (c_hi < 0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_v_r <= 1'b0;
    end else if (b_rdy) begin
      b_v_r <= a_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (b_rdy && a_v_r) begin
      b_cx_r    <= a_cx_r;
      b_cy_r    <= a_cy_r;
      b_cz_r    <= a_cz_r;
      b_rad_r   <= a_rad_r;
      b_flags_r <= b_flags_nxt;
    end
  end

  assign dn_valid = b_v_r;
  assign dn_cx    = b_cx_r;
  assign dn_cy    = b_cy_r;
  assign dn_cz    = b_cz_r;
  assign dn_rad   = b_rad_r;
  assign dn_flags = b_flags_r;

endmodule

// ===== design/frustum_cull_test.sv =====
// Frustum cull test top level: entry stage, row of plane cells, output register.
// Each object (centre, half-extents, skip_near in tuser) is tested as a sphere
// and as a cube against PLANE_COUNT planes written through the cfg port
// (index 0..5: near, far, left, right, top, bottom; 64 bits each, normal x/y/z
// Q1.14 in bits 15:0/31:16/47:32, signed distance in 63:48; higher indices
// ignored, planes past six stay zero). One object is accepted every cycle while
// the output is not stalled; results appear in order, registered through the
// entry stage, the row of two-stage plane cells and the output register.
// Stalls on the output fill empty stages first. Write planes only when idle.
module frustum_cull_test #(
  parameter int PLANE_COUNT = 6,
  parameter int COORD_BITS  = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [fc_pkg::REG_IDX_W-1:0]     cfg_index,
  input  logic [fc_pkg::PLANE_W-1:0]       cfg_wdata,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // center_x, center_y, center_z, extent_x, extent_y, extent_z, zero pad
  input  logic [((6*COORD_BITS-3+7)/8)*8-1:0] in_tdata,
  // skip_near
  input  logic                             in_tuser,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // visible, sphere_class, cube_class, zero pad
  output logic [fc_pkg::OUT_TDATA_W-1:0]   out_tdata
);
  import fc_pkg::*;

  localparam int CB = COORD_BITS;
  localparam int EW = CB - 1;

  logic signed [CB-1:0] in_cx, in_cy, in_cz;
  logic [EW-1:0]        in_ex, in_ey, in_ez, in_rad;

  logic                 e_v_r;
  logic signed [CB-1:0] e_cx_r, e_cy_r, e_cz_r;
  logic [EW-1:0]        e_rad_r;
  logic                 e_skip_r;
  fc_flags_t            e_flags;
  logic                 e_rdy;

  logic                 c_v   [PLANE_COUNT:0];
  logic                 c_rdy [PLANE_COUNT:0];
  logic signed [CB-1:0] c_cx  [PLANE_COUNT:0];
  logic signed [CB-1:0] c_cy  [PLANE_COUNT:0];
  logic signed [CB-1:0] c_cz  [PLANE_COUNT:0];
  logic [EW-1:0]        c_rad [PLANE_COUNT:0];
  fc_flags_t            c_flg [PLANE_COUNT:0];
  logic [PLANE_COUNT-1:0] plane_we;

  fc_flags_t            last_f;
  logic [1:0]           sph_nxt, cube_nxt;
  logic                 vis_nxt;
  logic                 o_v_r;
  logic [OUT_TDATA_W-1:0] o_data_r;
  logic                 o_rdy;

  assign cfg_ready = 1'b1;

  assign in_cx = in_tdata[0 +: CB];
  assign in_cy = in_tdata[CB +: CB];
  assign in_cz = in_tdata[2*CB +: CB];
  assign in_ex = in_tdata[3*CB +: EW];
  assign in_ey = in_tdata[3*CB+EW +: EW];
  assign in_ez = in_tdata[3*CB+2*EW +: EW];

  always_comb begin
    in_rad = in_ex;
    if (in_ey > in_rad) in_rad = in_ey;
    if (in_ez > in_rad) in_rad = in_ez;
  end

  assign e_rdy     = !e_v_r || c_rdy[0];
  assign in_tready = e_rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e_v_r <= 1'b0;
    end else if (e_rdy) begin
      e_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (e_rdy && in_tvalid) begin
      e_cx_r   <= in_cx;
      e_cy_r   <= in_cy;
      e_cz_r   <= in_cz;
      e_rad_r  <= in_rad;
      e_skip_r <= in_tuser;
    end
  end

  always_comb begin
    e_flags      = '0;
    e_flags.skip = e_skip_r;
  end

  assign c_v[0]   = e_v_r;
  assign c_cx[0]  = e_cx_r;
  assign c_cy[0]  = e_cy_r;
  assign c_cz[0]  = e_cz_r;
  assign c_rad[0] = e_rad_r;
  assign c_flg[0] = e_flags;

  for (genvar i = 0; i < PLANE_COUNT; i++) begin : g_cell
    if (i < REG_COUNT) begin : g_we
      assign plane_we[i] = cfg_valid && (cfg_index == REG_IDX_W'(i));
    end else begin : g_no_we
      assign plane_we[i] = 1'b0;
    end

    fc_cell #(
      .CB(CB)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .cfg_we   (plane_we[i]),
      .cfg_wdata(cfg_wdata),
      .up_valid (c_v[i]),
      .up_ready (c_rdy[i]),
      .up_cx    (c_cx[i]),
      .up_cy    (c_cy[i]),
      .up_cz    (c_cz[i]),
      .up_rad   (c_rad[i]),
      .up_flags (c_flg[i]),
      .dn_valid (c_v[i+1]),
      .dn_ready (c_rdy[i+1]),
      .dn_cx    (c_cx[i+1]),
      .dn_cy    (c_cy[i+1]),
      .dn_cz    (c_cz[i+1]),
      .dn_rad   (c_rad[i+1]),
      .dn_flags (c_flg[i+1])
    );
  end

  assign last_f = c_flg[PLANE_COUNT];

  always_comb begin
    if (last_f.skip) begin
      sph_nxt  = CLASS_INTERSECTS;
      cube_nxt = CLASS_INTERSECTS;
    end else begin
      sph_nxt  = last_f.sph_out ? CLASS_OUTSIDE :
                 (last_f.sph_cross ? CLASS_INTERSECTS : CLASS_INSIDE);
      cube_nxt = last_f.cube_out ? CLASS_OUTSIDE :
                 (last_f.cube_cross ? CLASS_INTERSECTS : CLASS_INSIDE);
    end
    vis_nxt = (sph_nxt != CLASS_OUTSIDE) || (cube_nxt != CLASS_OUTSIDE);
  end

  assign o_rdy              = !o_v_r || out_tready;
  assign c_rdy[PLANE_COUNT] = o_rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_v_r <= 1'b0;
    end else if (o_rdy) begin
      o_v_r <= c_v[PLANE_COUNT];
    end
  end

  always_ff @(posedge clk) begin
    if (o_rdy && c_v[PLANE_COUNT]) begin
      o_data_r <= OUT_TDATA_W'({cube_nxt, sph_nxt, vis_nxt});
    end
  end

  assign out_tvalid = o_v_r;
  assign out_tdata  = o_data_r;

  a_hidden_both_out: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tdata[0]) |->
      (out_tdata[2:1] == CLASS_OUTSIDE && out_tdata[4:3] == CLASS_OUTSIDE))
    else $error("hidden object without both tests outside");

  a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled while output register is empty");

  a_reset_empty: assert property (@(posedge clk)
    (rst_n && $past(!rst_n)) |-> !out_tvalid)
    else $error("result presented right after reset");

endmodule
